@@ rtl/u8u16pos_pkg.sv @@
// Shared types, constants and helpers for the UTF-8 scanner with UTF-16 positions.
// No dependencies; imported by utf8_stream_line_utf16_position_top.
package u8u16pos_pkg;

	localparam int CNT_W = 32;
	localparam int CP_W  = 21;

	typedef enum logic [1:0] {
		STATUS_VALID     = 2'd0,
		STATUS_SPLIT_SEQ = 2'd1,
		STATUS_SPLIT_CRLF = 2'd2,
		STATUS_MALFORMED = 2'd3
	} status_t;

	localparam logic [7:0] BYTE_LF     = 8'h0A;
	localparam logic [7:0] BYTE_CR     = 8'h0D;
	localparam logic [7:0] ASCII_LIMIT = 8'h80;
	localparam logic [7:0] LEAD2_LO    = 8'hC2;
	localparam logic [7:0] LEAD2_HI    = 8'hDF;
	localparam logic [7:0] LEAD3_LO    = 8'hE0;
	localparam logic [7:0] LEAD3_HI    = 8'hEF;
	localparam logic [7:0] LEAD4_LO    = 8'hF0;
	localparam logic [7:0] LEAD4_HI    = 8'hF4;

	localparam logic [CP_W-1:0] MIN_CP2       = 21'h000080;
	localparam logic [CP_W-1:0] MIN_CP3       = 21'h000800;
	localparam logic [CP_W-1:0] MIN_CP4       = 21'h010000;
	localparam logic [CP_W-1:0] MAX_CP        = 21'h10FFFF;
	localparam logic [CP_W-1:0] SURROGATE_LO  = 21'h00D800;
	localparam logic [CP_W-1:0] SURROGATE_HI  = 21'h00DFFF;
	localparam logic [CP_W-1:0] MAX_BMP       = 21'h00FFFF;

	localparam logic [1:0] LEN_NONE   = 2'd0;
	localparam logic [1:0] LEN_CLASS2 = 2'd1;
	localparam logic [1:0] LEN_CLASS3 = 2'd2;
	localparam logic [1:0] LEN_CLASS4 = 2'd3;

	typedef struct packed {
		logic [CNT_W-1:0] byte_offset;
		logic [CNT_W-1:0] line_number;
		logic [CNT_W-1:0] utf16_column;
		logic [CNT_W-1:0] utf16_total;
		status_t          status;
		logic [CP_W-1:0]  char_value;
		logic             char_done;
		logic             is_end;
	} result_t;

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
		input logic [1:0] u);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {{(CNT_W-1){1'b0}}, u};
		return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
	endfunction

endpackage

@@ rtl/utf8_stream_line_utf16_position_top.sv @@
// Strict UTF-8 scanner reporting line, UTF-16 column and UTF-16 total per byte offset.
// Depends on u8u16pos_pkg.

// Takes one document byte per transfer (is_last marks the final byte) and gives
// one position result per byte, plus an end-of-text result after the last byte.
// A byte is held in the input register and its result is then loaded into the
// output register once the result buffer has room. One byte is taken every
// cycle while the output side keeps up; after the final byte of a document the
// next byte waits, because the two-entry result buffer must drain its end-of-text
// entry before a new byte can be loaded. Malformed status is sticky until the
// end of the document, and all counters saturate at 0xFFFFFFFF.
module utf8_stream_line_utf16_position_top
	import u8u16pos_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           text_byte,
	input  logic                 is_last,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [CNT_W-1:0]     byte_offset,
	output logic [CNT_W-1:0]     line_number,
	output logic [CNT_W-1:0]     utf16_column,
	output logic [CNT_W-1:0]     utf16_total,
	output logic [1:0]           status,
	output logic [CP_W-1:0]      char_value,
	output logic                 char_done,
	output logic                 is_end
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// decoder and position state
	logic [1:0]       pend_q, pend_d;
	logic [CP_W-1:0]  partial_q, partial_d;
	logic [1:0]       len_class_q, len_class_d;
	logic             after_cr_q, after_cr_d;
	logic [CNT_W-1:0] line_q, line_d;
	logic [CNT_W-1:0] col_q, col_d;
	logic [CNT_W-1:0] units_q, units_d;
	logic [CNT_W-1:0] offset_q, offset_d;
	logic             malformed_q, malformed_d;

	// two-entry result buffer
	result_t    res_head_q, res_tail_q;
	logic [1:0] out_cnt_q;

	result_t          byte_res, end_res;
	logic             mid, crlf, done;
	logic [CP_W-1:0]  cp, cp_next, min_cp;
	logic [1:0]       pend_dec, units_add;
	logic             pop, load;

	assign pop       = (out_cnt_q != 2'd0) && !out_stall;
	assign load      = valid_s1 && ((out_cnt_q == 2'd0) || ((out_cnt_q == 2'd1) && pop));
	assign in_stall  = valid_s1 && !load;
	assign out_valid = (out_cnt_q != 2'd0);

	always_comb begin
		mid         = (pend_q != 2'd0);
		crlf        = !mid && after_cr_q && (byte_s1 == BYTE_LF);
		done        = 1'b0;
		cp          = '0;
		pend_d      = pend_q;
		partial_d   = partial_q;
		len_class_d = len_class_q;
		after_cr_d  = after_cr_q;
		line_d      = line_q;
		col_d       = col_q;
		units_d     = units_q;
		malformed_d = malformed_q;
		cp_next     = {partial_q[CP_W-7:0], byte_s1[5:0]};
		pend_dec    = pend_q - 2'd1;
		units_add   = (cp_next > MAX_BMP) ? 2'd2 : 2'd1;
		case (len_class_q)
			LEN_CLASS2: min_cp = MIN_CP2;
			LEN_CLASS3: min_cp = MIN_CP3;
			default:    min_cp = MIN_CP4;
		endcase

		if (!mid) begin
			after_cr_d = 1'b0;
			if (byte_s1 < ASCII_LIMIT) begin
				cp   = {{(CP_W-8){1'b0}}, byte_s1};
				done = 1'b1;
				if (byte_s1 == BYTE_CR) begin
					line_d     = sat_add(line_q, 2'd1);
					col_d      = '0;
					after_cr_d = 1'b1;
				end else if (byte_s1 == BYTE_LF) begin
					if (!crlf) begin
						line_d = sat_add(line_q, 2'd1);
						col_d  = '0;
					end
				end else begin
					col_d = sat_add(col_q, 2'd1);
				end
				units_d = sat_add(units_q, 2'd1);
			end else if (byte_s1 inside {[LEAD2_LO:LEAD2_HI]}) begin
				pend_d      = 2'd1;
				len_class_d = LEN_CLASS2;
				partial_d   = {{(CP_W-5){1'b0}}, byte_s1[4:0]};
			end else if (byte_s1 inside {[LEAD3_LO:LEAD3_HI]}) begin
				pend_d      = 2'd2;
				len_class_d = LEN_CLASS3;
				partial_d   = {{(CP_W-4){1'b0}}, byte_s1[3:0]};
			end else if (byte_s1 inside {[LEAD4_LO:LEAD4_HI]}) begin
				pend_d      = 2'd3;
				len_class_d = LEN_CLASS4;
				partial_d   = {{(CP_W-3){1'b0}}, byte_s1[2:0]};
			end else begin
				malformed_d = 1'b1;
			end
		end else if (byte_s1[7:6] == 2'b10) begin
			partial_d = cp_next;
			pend_d    = pend_dec;
			if (pend_dec == 2'd0) begin
				// finished sequence: reject overlong, out of range and surrogates
				if ((cp_next < min_cp) || (cp_next > MAX_CP) ||
				    ((cp_next >= SURROGATE_LO) && (cp_next <= SURROGATE_HI))) begin
					malformed_d = 1'b1;
				end else begin
					cp      = cp_next;
					done    = 1'b1;
					col_d   = sat_add(col_q, units_add);
					units_d = sat_add(units_q, units_add);
				end
				partial_d   = '0;
				len_class_d = LEN_NONE;
			end
		end else begin
			// missing continuation: drop the sequence and this byte
			malformed_d = 1'b1;
			pend_d      = '0;
			partial_d   = '0;
			len_class_d = LEN_NONE;
		end

		if (last_s1 && (pend_d != 2'd0))
			malformed_d = 1'b1;

		offset_d = sat_add(offset_q, 2'd1);

		byte_res.byte_offset     = offset_q;
		byte_res.line_number     = line_q;
		byte_res.utf16_column    = col_q;
		byte_res.utf16_total     = units_q;
		byte_res.status          = malformed_d ? STATUS_MALFORMED :
		                           mid ? STATUS_SPLIT_SEQ :
		                           crlf ? STATUS_SPLIT_CRLF : STATUS_VALID;
		byte_res.char_value      = cp;
		byte_res.char_done       = done;
		byte_res.is_end          = 1'b0;

		end_res.byte_offset     = offset_d;
		end_res.line_number     = line_d;
		end_res.utf16_column    = col_d;
		end_res.utf16_total     = units_d;
		end_res.status          = malformed_d ? STATUS_MALFORMED : STATUS_VALID;
		end_res.char_value      = '0;
		end_res.char_done       = 1'b0;
		end_res.is_end          = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= text_byte;
			last_s1 <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			partial_q   <= '0;
			len_class_q <= '0;
			after_cr_q  <= 1'b0;
			line_q      <= '0;
			col_q       <= '0;
			units_q     <= '0;
			offset_q    <= '0;
			malformed_q <= 1'b0;
		end else if (load) begin
			if (last_s1) begin
				// end of document: start the next one from scratch
				pend_q      <= '0;
				partial_q   <= '0;
				len_class_q <= '0;
				after_cr_q  <= 1'b0;
				line_q      <= '0;
				col_q       <= '0;
				units_q     <= '0;
				offset_q    <= '0;
				malformed_q <= 1'b0;
			end else begin
				pend_q      <= pend_d;
				partial_q   <= partial_d;
				len_class_q <= len_class_d;
				after_cr_q  <= after_cr_d;
				line_q      <= line_d;
				col_q       <= col_d;
				units_q     <= units_d;
				offset_q    <= offset_d;
				malformed_q <= malformed_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= '0;
		end else if (load) begin
			out_cnt_q <= last_s1 ? 2'd2 : 2'd1;
		end else if (pop) begin
			out_cnt_q <= out_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_head_q <= byte_res;
			res_tail_q <= end_res;
		end else if (pop) begin
			res_head_q <= res_tail_q;
		end
	end

	assign byte_offset     = res_head_q.byte_offset;
	assign line_number     = res_head_q.line_number;
	assign utf16_column    = res_head_q.utf16_column;
	assign utf16_total     = res_head_q.utf16_total;
	assign status          = res_head_q.status;
	assign char_value      = res_head_q.char_value;
	assign char_done       = res_head_q.char_done;
	assign is_end          = res_head_q.is_end;

`ifndef SYNTHESIS
	// after the per-byte result of a last byte goes, the end-of-text result follows
	a_end_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(out_cnt_q == 2'd2) && !out_stall |=> out_valid && is_end)
		else $error("end-of-text result missing after last byte");

	// an end-of-text result never carries a code point
	a_end_no_cp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_end |-> !char_done && (char_value == '0))
		else $error("end-of-text result carries a code point");

	// no new byte may be loaded while both result entries are occupied
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (out_cnt_q == 2'd2) |-> in_stall)
		else $error("input taken while result buffer full");
`endif

endmodule

@@ test/u8u16pos_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the UTF-8 scanner: predicts the position results from every input transfer
// and compares them with the output transfers. Depends on u8u16pos_pkg.
module u8u16pos_checker
	import u8u16pos_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  logic [7:0]       text_byte,
	input  logic             is_last,
	input  logic             out_valid,
	input  logic             out_stall,
	input  logic [CNT_W-1:0] byte_offset,
	input  logic [CNT_W-1:0] line_number,
	input  logic [CNT_W-1:0] utf16_column,
	input  logic [CNT_W-1:0] utf16_total,
	input  logic [1:0]       status,
	input  logic [CP_W-1:0]  char_value,
	input  logic             char_done,
	input  logic             is_end,
	output int               errors,
	output int               outstanding,
	output int               checked,
	output int               documents,
	output int               bad_documents,
	output int               char_count
);

	// decoder and position state
	logic [1:0]       pend;
	logic [CP_W-1:0]  partial;
	logic [1:0]       len_class;
	logic             after_cr;
	logic [CNT_W-1:0] line_cnt;
	logic [CNT_W-1:0] col_cnt;
	logic [CNT_W-1:0] unit_cnt;
	logic [CNT_W-1:0] offset_cnt;
	logic             bad;

	result_t expected_positions[$];
	result_t want;

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] a, input logic [1:0] inc);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {{(CNT_W-1){1'b0}}, inc};
		return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
	endfunction

	task automatic restart_document();
		pend = 2'd0;
		partial = '0;
		len_class = LEN_NONE;
		after_cr = 1'b0;
		line_cnt = '0;
		col_cnt = '0;
		unit_cnt = '0;
		offset_cnt = '0;
		bad = 1'b0;
	endtask

	task automatic scan_byte(input logic [7:0] b, input logic last);
		result_t r;
		logic mid;
		logic crlf;
		logic done;
		logic [CP_W-1:0] cp;
		logic [CP_W-1:0] v;
		logic [CP_W-1:0] minv;
		mid = (pend != 2'd0);
		crlf = !mid && after_cr && (b == BYTE_LF);
		done = 1'b0;
		cp = '0;
		r.byte_offset = offset_cnt;
		r.line_number = line_cnt;
		r.utf16_column = col_cnt;
		r.utf16_total = unit_cnt;
		if (!mid) begin
			after_cr = 1'b0;
			if (b < ASCII_LIMIT) begin
				cp = {13'd0, b};
				done = 1'b1;
				if (b == BYTE_CR) begin
					line_cnt = bump(line_cnt, 2'd1);
					col_cnt = '0;
					after_cr = 1'b1;
				end else if (b == BYTE_LF) begin
					// LF closing a CRLF was already counted with the CR
					if (!crlf) begin
						line_cnt = bump(line_cnt, 2'd1);
						col_cnt = '0;
					end
				end else begin
					col_cnt = bump(col_cnt, 2'd1);
				end
				unit_cnt = bump(unit_cnt, 2'd1);
			end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
				pend = 2'd1;
				len_class = LEN_CLASS2;
				partial = {16'd0, b[4:0]};
			end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
				pend = 2'd2;
				len_class = LEN_CLASS3;
				partial = {17'd0, b[3:0]};
			end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
				pend = 2'd3;
				len_class = LEN_CLASS4;
				partial = {18'd0, b[2:0]};
			end else begin
				bad = 1'b1;
			end
		end else if (b[7:6] == 2'b10) begin
			partial = {partial[14:0], b[5:0]};
			pend = pend - 2'd1;
			if (pend == 2'd0) begin
				v = partial;
				minv = (len_class == LEN_CLASS2) ? MIN_CP2 :
					(len_class == LEN_CLASS3) ? MIN_CP3 : MIN_CP4;
				if (v < minv || v > MAX_CP || (v >= SURROGATE_LO && v <= SURROGATE_HI)) begin
					bad = 1'b1;
				end else begin
					cp = v;
					done = 1'b1;
					col_cnt = bump(col_cnt, (v > MAX_BMP) ? 2'd2 : 2'd1);
					unit_cnt = bump(unit_cnt, (v > MAX_BMP) ? 2'd2 : 2'd1);
				end
				partial = '0;
				len_class = LEN_NONE;
			end
		end else begin
			// sequence abandoned, offending byte dropped
			bad = 1'b1;
			pend = 2'd0;
			partial = '0;
			len_class = LEN_NONE;
		end
		if (last && pend != 2'd0)
			bad = 1'b1;
		r.status = bad ? STATUS_MALFORMED : mid ? STATUS_SPLIT_SEQ :
			crlf ? STATUS_SPLIT_CRLF : STATUS_VALID;
		r.char_value = cp;
		r.char_done = done;
		r.is_end = 1'b0;
		expected_positions.push_back(r);
		offset_cnt = bump(offset_cnt, 2'd1);
		if (last) begin
			r.byte_offset = offset_cnt;
			r.line_number = line_cnt;
			r.utf16_column = col_cnt;
			r.utf16_total = unit_cnt;
			r.status = bad ? STATUS_MALFORMED : STATUS_VALID;
			r.char_value = '0;
			r.char_done = 1'b0;
			r.is_end = 1'b1;
			expected_positions.push_back(r);
			restart_document();
		end
	endtask

	task automatic check_field(input string name, input logic [CNT_W-1:0] exp_v,
		input logic [CNT_W-1:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_document();
			expected_positions.delete();
			errors = 0;
			outstanding = 0;
			checked = 0;
			documents = 0;
			bad_documents = 0;
			char_count = 0;
		end else begin
			if (in_valid && !in_stall)
				scan_byte(text_byte, is_last);
			if (out_valid && !out_stall) begin
				if (expected_positions.size() == 0) begin
					$error("unexpected result transfer at offset %0d", byte_offset);
					errors++;
				end else begin
					want = expected_positions.pop_front();
					check_field("byte_offset", want.byte_offset, byte_offset);
					check_field("line_number", want.line_number, line_number);
					check_field("utf16_column", want.utf16_column, utf16_column);
					check_field("utf16_total", want.utf16_total, utf16_total);
					check_field("status", CNT_W'(want.status), CNT_W'(status));
					check_field("char_value", CNT_W'(want.char_value), CNT_W'(char_value));
					check_field("char_done", CNT_W'(want.char_done), CNT_W'(char_done));
					check_field("is_end", CNT_W'(want.is_end), CNT_W'(is_end));
					checked++;
					if (want.is_end) begin
						documents++;
						if (want.status == STATUS_MALFORMED)
							bad_documents++;
					end
					if (want.char_done)
						char_count++;
				end
			end
			outstanding = expected_positions.size();
		end
	end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// Top of the UTF-8 scanner testbench: clock, reset, byte stream stimulus and verdict.
// Depends on u8u16pos_pkg, utf8_stream_line_utf16_position_top and u8u16pos_checker.
module tb_top
	import u8u16pos_pkg::*;
();

	localparam int PHASE_BYTES = 360;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int DIRECTED_LEN = 28;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [7:0] text_byte;
	logic is_last;
	logic out_valid;
	logic out_stall;
	logic [CNT_W-1:0] byte_offset;
	logic [CNT_W-1:0] line_number;
	logic [CNT_W-1:0] utf16_column;
	logic [CNT_W-1:0] utf16_total;
	logic [1:0] status;
	logic [CP_W-1:0] char_value;
	logic char_done;
	logic is_end;

	int errors;
	int outstanding;
	int checked;
	int documents;
	int bad_documents;
	int char_count;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_req = 0;
	int sent_bytes = 0;
	logic [7:0] doc_bytes[$];

	int send_idle_by_phase[4] = '{0, 70, 0, 17};
	int recv_stall_by_phase[4] = '{0, 0, 70, 17};

	// bit 8 flags the last byte of a document
	logic [8:0] directed[DIRECTED_LEN] = '{
		9'h0C2, 9'h080, 9'h00D, 9'h00A, 9'h0F4, 9'h08F, 9'h0BF, 9'h0BF, 9'h00D, 9'h10D,
		9'h0ED, 9'h0A0, 9'h080, 9'h17F,
		9'h0C3, 9'h041, 9'h0C0, 9'h1FF,
		9'h0E0, 9'h1A0,
		9'h0F0, 9'h090, 9'h080, 9'h080, 9'h0EF, 9'h0BF, 9'h0BF, 9'h100
	};

	always #4 clk = ~clk;

	utf8_stream_line_utf16_position_top u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.text_byte      (text_byte),
		.is_last        (is_last),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.byte_offset    (byte_offset),
		.line_number    (line_number),
		.utf16_column   (utf16_column),
		.utf16_total    (utf16_total),
		.status         (status),
		.char_value     (char_value),
		.char_done      (char_done),
		.is_end         (is_end)
	);

	u8u16pos_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.text_byte      (text_byte),
		.is_last        (is_last),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.byte_offset    (byte_offset),
		.line_number    (line_number),
		.utf16_column   (utf16_column),
		.utf16_total    (utf16_total),
		.status         (status),
		.char_value     (char_value),
		.char_done      (char_done),
		.is_end         (is_end),
		.errors         (errors),
		.outstanding    (outstanding),
		.checked        (checked),
		.documents      (documents),
		.bad_documents  (bad_documents),
		.char_count     (char_count)
	);

	// receiver: random stall, plus one long hold-off on request
	initial begin
		int holds_done;
		holds_done = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != holds_done) begin
				holds_done++;
				repeat (HOLD_CYCLES) begin
					out_stall <= 1'b1;
					@(negedge clk);
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		text_byte <= b;
		is_last <= last;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
		sent_bytes++;
	endtask

	task automatic encode(input logic [CP_W-1:0] cp, input int len);
		case (len)
			1: doc_bytes.push_back(cp[7:0]);
			2: begin
				doc_bytes.push_back({3'b110, cp[10:6]});
				doc_bytes.push_back({2'b10, cp[5:0]});
			end
			3: begin
				doc_bytes.push_back({4'b1110, cp[15:12]});
				doc_bytes.push_back({2'b10, cp[11:6]});
				doc_bytes.push_back({2'b10, cp[5:0]});
			end
			default: begin
				doc_bytes.push_back({5'b11110, cp[20:18]});
				doc_bytes.push_back({2'b10, cp[17:12]});
				doc_bytes.push_back({2'b10, cp[11:6]});
				doc_bytes.push_back({2'b10, cp[5:0]});
			end
		endcase
	endtask

	// mostly well-formed text; faulty characters only in some documents
	task automatic build_document(input bit allow_faults);
		int n;
		int kind;
		int len;
		logic [CP_W-1:0] cp;
		doc_bytes.delete();
		n = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
		repeat (n) begin
			kind = $urandom_range(99);
			if (kind < 28) begin
				encode(CP_W'($urandom_range(0, 'h7F)), 1);
			end else if (kind < 36) begin
				doc_bytes.push_back(BYTE_CR);
			end else if (kind < 44) begin
				doc_bytes.push_back(BYTE_LF);
			end else if (kind < 52) begin
				doc_bytes.push_back(BYTE_CR);
				doc_bytes.push_back(BYTE_LF);
			end else if (kind < 64) begin
				encode(CP_W'($urandom_range('h80, 'h7FF)), 2);
			end else if (kind < 76) begin
				cp = CP_W'($urandom_range('h800, 'hFFFF));
				if (cp >= SURROGATE_LO && cp <= SURROGATE_HI)
					cp = cp ^ 21'h004000;
				encode(cp, 3);
			end else if (kind < 88 || !allow_faults) begin
				encode(CP_W'($urandom_range('h10000, 'h10FFFF)), 4);
			end else begin
				case ($urandom_range(5))
					0: doc_bytes.push_back(8'($urandom_range(0, 255)));
					1: begin
						// overlong form
						len = $urandom_range(2, 4);
						encode(CP_W'($urandom_range(0,
							(len == 2) ? 'h7F : (len == 3) ? 'h7FF : 'hFFFF)), len);
					end
					2: encode(CP_W'($urandom_range('hD800, 'hDFFF)), 3);
					3: encode(CP_W'($urandom_range('h110000, 'h1FFFFF)), 4);
					4: begin
						// sequence cut short
						len = $urandom_range(2, 4);
						encode(CP_W'($urandom_range(0, 'h1FFFFF)), len);
						repeat ($urandom_range(1, len - 1))
							void'(doc_bytes.pop_back());
					end
					default: doc_bytes.push_back(8'($urandom_range('h80, 'hBF)));
				endcase
			end
		end
	endtask

	initial begin
		int phase_bytes;
		arst_n = 1'b0;
		in_valid = 1'b0;
		text_byte = 8'h00;
		is_last = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i])
			send_byte(directed[i][7:0], directed[i][8]);
		in_valid <= 1'b0;
		wait (outstanding == 0);
		@(negedge clk);

		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = send_idle_by_phase[phase];
			recv_stall_pct = recv_stall_by_phase[phase];
			// back-pressure: receiver holds off while the sender keeps going
			if (phase == 0)
				hold_req++;
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) begin
				build_document($urandom_range(3) == 0);
				foreach (doc_bytes[i])
					send_byte(doc_bytes[i], i == doc_bytes.size() - 1);
				phase_bytes += doc_bytes.size();
				if ($urandom_range(9) == 0) begin
					in_valid <= 1'b0;
					wait (outstanding == 0);
					@(negedge clk);
				end
			end
			in_valid <= 1'b0;
			wait (outstanding == 0);
			@(negedge clk);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d bytes in %0d documents, %0d of them malformed", sent_bytes,
			documents, bad_documents);
		$display("checked %0d results, %0d completed code points", checked, char_count);
		if (errors == 0 && outstanding == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/u8u16pos_pkg.sv
rtl/utf8_stream_line_utf16_position_top.sv
test/u8u16pos_checker.sv
test/tb_top.sv
